// ===== sv/lidar_scan_cluster_centroids_top_macros.svh =====
// assertion helpers for the lidar cluster block
`ifndef LIDAR_SCAN_CLUSTER_CENTROIDS_TOP_MACROS_SVH
`define LIDAR_SCAN_CLUSTER_CENTROIDS_TOP_MACROS_SVH

// property holds every cycle outside reset
`define LSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define LSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/lsc_pkg.sv =====
//------------------------------------------------------------------------------
// lsc_pkg
// shared types and constants for the lidar cluster block
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package lsc_pkg;

  localparam int MaxSamples = 4096;
  localparam int IdxW       = $clog2(MaxSamples);
  localparam int ClusterCap = 4096;
  localparam logic [12:0] TallyMax = 13'd8191;
  localparam int PaddrW     = 5;
  localparam int QDepth     = 4;
  localparam int QPtrW      = $clog2(QDepth);

  localparam logic [PaddrW-1:0] RegAngleStart = 5'd0;
  localparam logic [PaddrW-1:0] RegAngleStep  = 5'd4;
  localparam logic [PaddrW-1:0] RegRangeMin   = 5'd8;
  localparam logic [PaddrW-1:0] RegRangeMax   = 5'd12;
  localparam logic [PaddrW-1:0] RegJoinDist   = 5'd16;
  localparam logic [PaddrW-1:0] RegMinPoints  = 5'd20;

  localparam logic KindCentroid = 1'b0;
  localparam logic KindSummary  = 1'b1;

  // one closed cluster or summary request for the back end
  typedef struct packed {
    logic        summary;
    logic        last;
    logic signed [29:0] sum_x;
    logic signed [29:0] sum_y;
    logic [12:0] count;
    logic [12:0] total;
  } job_t;

  typedef struct packed {
    logic        kind;
    logic signed [16:0] cx;
    logic signed [16:0] cy;
    logic [12:0] cnt;
    logic [12:0] total;
    logic        fin;
  } res_t;

endpackage

// ===== sv/lsc_if.sv =====
//------------------------------------------------------------------------------
// lsc_in_if / lsc_out_if
// valid/ready channels for samples and results
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
interface lsc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        invalid;
  logic        scan_end;
  modport source (output valid, range_mm, invalid, scan_end, input ready);
  modport sink   (input valid, range_mm, invalid, scan_end, output ready);
endinterface

interface lsc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic signed [16:0] mean_x;
  logic signed [16:0] mean_y;
  logic [12:0] point_count;
  logic [12:0] cluster_total;
  logic        final_res;
  modport source (output valid, kind, mean_x, mean_y, point_count,
                  cluster_total, final_res, input ready);
  modport sink   (input valid, kind, mean_x, mean_y, point_count,
                  cluster_total, final_res, output ready);
endinterface

// ===== sv/lsc_front.sv =====
//------------------------------------------------------------------------------
// lsc_front
// converts samples to points, tracks the open cluster, issues jobs
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module lsc_front
  import lsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] range_mm,
  input  logic        invalid,
  input  logic        scan_end,
  input  logic [15:0] angle_start,
  input  logic [15:0] angle_step,
  input  logic [15:0] range_min,
  input  logic [15:0] range_max,
  input  logic [11:0] join_distance,
  input  logic [12:0] min_points,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TRIG  = 5'b00010,
    S_CALC  = 5'b00100,
    S_DIST  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state;
  logic [IdxW-1:0] sample_index;
  logic signed [17:0] prev_x, prev_y, x, y;
  logic signed [29:0] sum_x, sum_y;
  logic [12:0] open_points, clusters_found;
  logic [15:0] r;
  logic bad, last;
  logic signed [16:0] sin_q, cos_q;
  logic signed [32:0] px, py;
  logic [24:0] dsq;
  logic [23:0] jsq;
  // pending jobs: closed cluster, flushed cluster, summary
  logic [2:0] pend;
  job_t j_closed, j_flush;
  logic [15:0] angle, ang, ang_c;
  logic [1:0] phase;
  logic [14:0] t_s, t_c, s_s, s_c;
  logic [15:0] t2_s, t2_c, pq_s, pq_c;
  logic [29:0] tt_s, tt_c;
  logic [27:0] m1_s, m1_c;
  logic [31:0] m2_s, m2_c;
  logic [30:0] m3_s, m3_c;
  logic signed [16:0] sv_s, sv_c;
  logic form_flush;
  logic [12:0] mp_eff;
  logic signed [18:0] dx, dy;
  logic [17:0] adx, ady;

  assign mp_eff = (min_points == 13'd0) ? 13'd1 : min_points;
  assign angle = angle_start + 16'(sample_index) * angle_step;
  assign in_ready = (state == S_IDLE);

  // quarter-wave sine for both lanes, one multiply per step
  assign ang_c = ang + 16'd16384;
  assign t_s = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
  assign t_c = ang_c[14] ? (15'd16384 - {1'b0, ang_c[13:0]}) : {1'b0, ang_c[13:0]};
  assign tt_s = {15'd0, t_s} * {15'd0, t_s};
  assign tt_c = {15'd0, t_c} * {15'd0, t_c};
  assign m1_s = {12'd0, t2_s} * 28'd2320;
  assign m1_c = {12'd0, t2_c} * 28'd2320;
  assign m2_s = {16'd0, t2_s} * {16'd0, pq_s};
  assign m2_c = {16'd0, t2_c} * {16'd0, pq_c};
  assign m3_s = {16'd0, t_s} * {15'd0, pq_s};
  assign m3_c = {16'd0, t_c} * {15'd0, pq_c};
  assign s_s = (m3_s[30:14] > 17'd32767) ? 15'h7FFF : m3_s[28:14];
  assign s_c = (m3_c[30:14] > 17'd32767) ? 15'h7FFF : m3_c[28:14];
  assign sv_s = ang[15] ? -$signed({2'b00, s_s}) : $signed({2'b00, s_s});
  assign sv_c = ang_c[15] ? -$signed({2'b00, s_c}) : $signed({2'b00, s_c});

  assign px = $signed({17'd0, r}) * cos_q;
  assign py = $signed({17'd0, r}) * sin_q;

  // dx,dy only reach the squared compare when both fit in 12 bits
  assign dx = {x[17], x} - {prev_x[17], prev_x};
  assign dy = {y[17], y} - {prev_y[17], prev_y};
  assign adx = dx[18] ? 18'(-dx) : dx[17:0];
  assign ady = dy[18] ? 18'(-dy) : dy[17:0];
  assign dsq = {13'd0, adx[11:0]} * {13'd0, adx[11:0]}
             + {13'd0, ady[11:0]} * {13'd0, ady[11:0]};

  // scan end folds the open cluster into a flush job before the summary goes
  assign form_flush = (state == S_EMIT) && last && pend[2] && !pend[0] && !pend[1]
                      && (open_points != 13'd0);

  function automatic logic report(input logic [12:0] n, input logic [12:0] mp);
    report = (n != 13'd0) && (n >= mp);
  endfunction

  always_comb begin
    job_valid = 1'b0;
    job = '0;
    if (state == S_EMIT && !form_flush) begin
      if (pend[0]) begin
        job_valid = 1'b1;
        job = j_closed;
        job.last = !pend[1] && !pend[2];
      end else if (pend[1]) begin
        job_valid = 1'b1;
        job = j_flush;
        job.last = !pend[2];
      end else if (pend[2]) begin
        job_valid = 1'b1;
        job.summary = 1'b1;
        job.last = 1'b1;
        job.total = clusters_found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sample_index <= '0;
      prev_x <= '0; prev_y <= '0; sum_x <= '0; sum_y <= '0;
      open_points <= '0; clusters_found <= '0;
      pend <= '0;
      phase <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            r <= range_mm;
            bad <= invalid || range_mm < range_min || range_mm > range_max;
            last <= scan_end;
            ang <= angle;
            phase <= 2'd0;
            pend <= '0;
            state <= S_TRIG;
          end
        end
        S_TRIG: begin
          unique case (phase)
            2'd0: begin
              t2_s <= tt_s[29:14]; t2_c <= tt_c[29:14];
            end
            2'd1: begin
              pq_s <= 16'd21024 - {2'b00, m1_s[27:14]};
              pq_c <= 16'd21024 - {2'b00, m1_c[27:14]};
            end
            2'd2: begin
              pq_s <= 16'd51472 - m2_s[29:14];
              pq_c <= 16'd51472 - m2_c[29:14];
            end
            2'd3: begin
              sin_q <= sv_s;
              cos_q <= sv_c;
              state <= S_CALC;
            end
          endcase
          phase <= phase + 2'd1;
        end
        S_CALC: begin
          x <= 18'(px >>> 15);
          y <= 18'(py >>> 15);
          state <= S_DIST;
        end
        S_DIST: begin
          logic close_now;
          logic [12:0] cf;
          close_now = 1'b0;
          cf = clusters_found;
          if (bad) close_now = 1'b1;
          else if (open_points != 13'd0) begin
            if (open_points >= 13'(ClusterCap) || adx >= 18'(join_distance)
                || ady >= 18'(join_distance) || dsq >= {1'b0, jsq})
              close_now = 1'b1;
          end
          if (close_now && report(open_points, mp_eff)) begin
            if (cf < TallyMax) cf = cf + 13'd1;
            j_closed <= '{summary: 1'b0, last: 1'b0, sum_x: sum_x, sum_y: sum_y,
                          count: open_points, total: cf};
            pend[0] <= 1'b1;
          end
          if (bad) begin
            open_points <= '0; sum_x <= '0; sum_y <= '0;
          end else if (open_points == 13'd0 || close_now) begin
            open_points <= 13'd1;
            sum_x <= 30'(x); sum_y <= 30'(y);
            prev_x <= x; prev_y <= y;
          end else begin
            open_points <= open_points + 13'd1;
            sum_x <= sum_x + 30'(x); sum_y <= sum_y + 30'(y);
            prev_x <= x; prev_y <= y;
          end
          clusters_found <= cf;
          sample_index <= sample_index + 1'b1;
          state <= S_EMIT;
          if (last) begin
            // flush uses the post-update cluster, computed in emit
            pend[2] <= 1'b1;
          end
        end
        S_EMIT: begin
          if (last && !pend[2] && !pend[1] && !pend[0]) begin
            state <= S_IDLE;
          end else if (form_flush) begin
            if (report(open_points, mp_eff)) begin
              j_flush <= '{summary: 1'b0, last: 1'b0, sum_x: sum_x, sum_y: sum_y,
                           count: open_points,
                           total: (clusters_found < TallyMax) ?
                                  clusters_found + 13'd1 : clusters_found};
              if (clusters_found < TallyMax) clusters_found <= clusters_found + 13'd1;
              pend[1] <= 1'b1;
            end
            open_points <= '0; sum_x <= '0; sum_y <= '0;
          end else if (job_valid && job_ready) begin
            if (pend[0]) pend[0] <= 1'b0;
            else if (pend[1]) pend[1] <= 1'b0;
            else begin
              pend[2] <= 1'b0;
              clusters_found <= '0;
              sample_index <= '0;
              prev_x <= '0; prev_y <= '0;
            end
          end else if (!last && !pend[0]) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    jsq <= join_distance * join_distance;
  end

  `include "lidar_scan_cluster_centroids_top_macros.svh"
  `LSC_ASSERT(a_onehot, $onehot(state), "state not one-hot")
  `LSC_ASSERT(a_ready_idle, in_ready == (state == S_IDLE), "ready outside idle")
  `LSC_ASSERT_NEXT(a_accept, in_valid && in_ready, state == S_TRIG, "no trig after accept")
endmodule

// ===== sv/lsc_queue.sv =====
//------------------------------------------------------------------------------
// lsc_queue
// short fifo between the cluster tracker and the divider
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module lsc_queue
  import lsc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);
  job_t mem [QDepth];
  logic [QPtrW-1:0] wp, rp;
  logic [QPtrW:0] cnt;
  logic push, pop;

  assign in_ready = cnt != (QPtrW+1)'(QDepth);
  assign out_valid = cnt != '0;
  assign out_job = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

  `include "lidar_scan_cluster_centroids_top_macros.svh"
  `LSC_ASSERT(a_bound, cnt <= (QPtrW+1)'(QDepth), "queue overflow")
  `LSC_ASSERT_NEXT(a_inc, push && !pop, cnt == $past(cnt) + 1'b1, "count slip")
  `LSC_ASSERT_NEXT(a_dec, pop && !push, cnt == $past(cnt) - 1'b1, "count slip")
endmodule

// ===== sv/lsc_divider.sv =====
//------------------------------------------------------------------------------
// lsc_divider
// restoring divider for centroid sums, one quotient bit per cycle
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module lsc_divider
  import lsc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);
  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_OUT  = 3'b100
  } dstate_t;

  dstate_t state;
  job_t cur;
  logic [29:0] qx, qy;
  logic [12:0] remx, remy;
  logic [4:0] bitn;
  logic [29:0] ax, ay;
  logic [13:0] tx, ty;

  assign job_ready = (state == D_IDLE);
  assign res_valid = (state == D_OUT);
  assign tx = {remx, qx[29]};
  assign ty = {remy, qy[29]};

  always_comb begin
    res.kind = cur.summary ? KindSummary : KindCentroid;
    res.cx = cur.summary ? '0 : (cur.sum_x[29] ? 17'(-$signed(qx)) : 17'(qx));
    res.cy = cur.summary ? '0 : (cur.sum_y[29] ? 17'(-$signed(qy)) : 17'(qy));
    res.cnt = cur.summary ? '0 : cur.count;
    res.total = cur.total;
    res.fin = cur.last;
  end

  assign ax = job.sum_x[29] ? 30'(-job.sum_x) : job.sum_x;
  assign ay = job.sum_y[29] ? 30'(-job.sum_y) : job.sum_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      unique case (state)
        D_IDLE: if (job_valid) begin
          cur <= job;
          qx <= ax; qy <= ay; remx <= '0; remy <= '0; bitn <= 5'd0;
          state <= job.summary ? D_OUT : D_RUN;
        end
        D_RUN: begin
          if (tx >= {1'b0, cur.count}) begin
            remx <= 13'(tx - {1'b0, cur.count}); qx <= {qx[28:0], 1'b1};
          end else begin
            remx <= tx[12:0]; qx <= {qx[28:0], 1'b0};
          end
          if (ty >= {1'b0, cur.count}) begin
            remy <= 13'(ty - {1'b0, cur.count}); qy <= {qy[28:0], 1'b1};
          end else begin
            remy <= ty[12:0]; qy <= {qy[28:0], 1'b0};
          end
          bitn <= bitn + 5'd1;
          if (bitn == 5'd29) state <= D_OUT;
        end
        D_OUT: if (res_ready) state <= D_IDLE;
        default: state <= D_IDLE;
      endcase
    end
  end

  `include "lidar_scan_cluster_centroids_top_macros.svh"
  `LSC_ASSERT(a_d_onehot, $onehot(state), "divider state")
  `LSC_ASSERT_NEXT(a_hold, res_valid && !res_ready, res_valid && $stable(res), "result drop")
  `LSC_ASSERT(a_nzdiv, state != D_RUN || cur.count != 13'd0, "zero divisor")
endmodule

// ===== sv/lidar_scan_cluster_centroids_top.sv =====
// Lidar scan segmentation: each sample passes through the tracker's steps
// (accept, four steps of sine and cosine, point multiply, cluster update,
// release), staying in release while it issues jobs and, at scan end, to fold
// an open cluster into a flush job; the shared serial divider works out each
// reported cluster bit by bit and passes a summary straight to output, with a
// four-entry job queue between tracker and divider. Up to three results per
// sample: closed cluster, flushed cluster, end-of-scan summary.
//------------------------------------------------------------------------------
// lidar_scan_cluster_centroids_top
// apb config, sample and result channels
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module lidar_scan_cluster_centroids_top
  import lsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  lsc_in_if.sink            in_ch,
  lsc_out_if.source         out_ch
);
  logic [15:0] angle_start, angle_step, range_min, range_max;
  logic [11:0] join_distance;
  logic [12:0] min_points;
  logic fj_valid, fj_ready, qj_valid, qj_ready;
  job_t fj, qj;
  res_t res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_start <= 16'd0; angle_step <= 16'd182; range_min <= 16'd100;
      range_max <= 16'd5000; join_distance <= 12'd150; min_points <= 13'd3;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        RegAngleStart: angle_start <= pwdata[15:0];
        RegAngleStep:  angle_step <= pwdata[15:0];
        RegRangeMin:   range_min <= pwdata[15:0];
        RegRangeMax:   range_max <= pwdata[15:0];
        RegJoinDist:   join_distance <= pwdata[11:0];
        RegMinPoints:  min_points <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      RegAngleStart: prdata = {16'd0, angle_start};
      RegAngleStep:  prdata = {16'd0, angle_step};
      RegRangeMin:   prdata = {16'd0, range_min};
      RegRangeMax:   prdata = {16'd0, range_max};
      RegJoinDist:   prdata = {20'd0, join_distance};
      RegMinPoints:  prdata = {19'd0, min_points};
      default:       prdata = 32'd0;
    endcase
  end

  lsc_front u_front (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .range_mm(in_ch.range_mm), .invalid(in_ch.invalid), .scan_end(in_ch.scan_end),
    .angle_start, .angle_step, .range_min, .range_max, .join_distance, .min_points,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  lsc_queue u_queue (
    .clk, .rst, .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
    .out_valid(qj_valid), .out_ready(qj_ready), .out_job(qj)
  );

  lsc_divider u_div (
    .clk, .rst, .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res
  );

  assign out_ch.kind = res.kind;
  assign out_ch.mean_x = res.cx;
  assign out_ch.mean_y = res.cy;
  assign out_ch.point_count = res.cnt;
  assign out_ch.cluster_total = res.total;
  assign out_ch.final_res = res.fin;
endmodule
